/* rtl/core/rc4_stream_cipher_assert.svh */
// Assertion macros for the RC4 stream cipher RTL.
// No dependencies; included by the modules that carry checks.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RC4SC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rc4sc assertion failed");
// next-cycle implication
`define RC4SC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rc4sc assertion failed");
`else
`define RC4SC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define RC4SC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/rc4sc_pkg.sv */
// Shared types and constants for the RC4 stream cipher.
// No dependencies.
package rc4sc_pkg;

  localparam int DEFAULT_MAX_KEY_BYTES = 256;
  localparam int LEN_W                 = 9;
  localparam logic [LEN_W-1:0] KEY_LENGTH_RESET = 9'd16;

  // function codes
  localparam logic [1:0] FUNC_KEY_WRITE = 2'd0;
  localparam logic [1:0] FUNC_SCHEDULE  = 2'd1;
  localparam logic [1:0] FUNC_DATA      = 2'd2;

  // permutation memory access, one write and two reads a cycle
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr0;
    logic [7:0] raddr1;
  } perm_req_t;

endpackage

/* rtl/core/rc4sc_perm_ram.sv */
// 256 x 8 permutation memory: one write port, two registered read ports.
// Depends on rc4sc_pkg (perm_req_t). Reads return the old word on a collision.
module rc4sc_perm_ram (
  input  logic                 clk,
  input  rc4sc_pkg::perm_req_t req,
  output logic [7:0]           rd0,
  output logic [7:0]           rd1
);

  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd0 <= mem[req.raddr0];
    rd1 <= mem[req.raddr1];
  end

endmodule

/* rtl/core/rc4sc_key_ram.sv */
// Key byte store: one write port, one registered read port.
// Depends on rc4sc_pkg for the default depth.
module rc4sc_key_ram #(
  parameter int DEPTH = rc4sc_pkg::DEFAULT_MAX_KEY_BYTES,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/rc4sc_ctrl.sv */
// Sequencer for key schedule and keystream steps; drives both memories.
// Depends on rc4sc_pkg and rc4_stream_cipher_assert.svh.
`include "rc4_stream_cipher_assert.svh"
module rc4sc_ctrl #(
  parameter int MAX_KEY_BYTES = rc4sc_pkg::DEFAULT_MAX_KEY_BYTES,
  parameter int KIDX_W        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    func,
  input  logic [7:0]                    data_byte,
  input  logic [rc4sc_pkg::LEN_W-1:0]   key_last,
  input  logic [7:0]                    perm_rd0,
  input  logic [7:0]                    perm_rd1,
  input  logic [7:0]                    key_rd,
  output rc4sc_pkg::perm_req_t          perm_req,
  output logic [KIDX_W-1:0]             key_raddr,
  output logic                          busy,
  output logic [7:0]                    out_byte,
  output logic                          out_valid
);

  typedef enum logic [3:0] {
    IDLE,
    INIT,
    KS_RD_I,
    KS_RD_J,
    KS_WR_I,
    KS_WR_J,
    DS_RD_I,
    DS_RD_J,
    DS_WR_I,
    DS_WR_J
  } state_t;

  state_t            state;
  logic [7:0]        i;
  logic [7:0]        j;
  logic [7:0]        n;
  logic [KIDX_W-1:0] k;
  logic [7:0]        si;
  logic [7:0]        sj;
  logic [7:0]        t;
  logic [7:0]        data;
  logic [7:0]        j_next;
  logic [7:0]        ks;
  logic              accept;

  assign busy      = (state != IDLE);
  assign accept    = start && !busy;
  assign key_raddr = k;

  // j update: key byte only joins in during the schedule
  assign j_next = j + perm_rd0 + ((state == KS_RD_J) ? key_rd : 8'd0);

  // S[t] was read before S[i], S[j] were rewritten: forward (j wins)
  assign ks = (t == j) ? si : ((t == i) ? sj : perm_rd0);

  always_comb begin
    perm_req = '0;
    unique case (state)
      INIT: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = n;
        perm_req.wdata = n;
      end
      KS_RD_I: perm_req.raddr0 = n;
      KS_RD_J: perm_req.raddr1 = j_next;
      KS_WR_I: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = n;
        perm_req.wdata = perm_rd1;
      end
      KS_WR_J: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = j;
        perm_req.wdata = si;
      end
      DS_RD_I: perm_req.raddr0 = i;
      DS_RD_J: perm_req.raddr1 = j_next;
      DS_WR_I: begin
        perm_req.we     = 1'b1;
        perm_req.waddr  = i;
        perm_req.wdata  = perm_rd1;
        perm_req.raddr0 = si + perm_rd1;
      end
      DS_WR_J: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = j;
        perm_req.wdata = si;
      end
      default: perm_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      i         <= '0;
      j         <= '0;
      n         <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept && func == rc4sc_pkg::FUNC_SCHEDULE) begin
            n     <= '0;
            state <= INIT;
          end else if (accept && func == rc4sc_pkg::FUNC_DATA) begin
            i     <= i + 8'd1;
            data  <= data_byte;
            state <= DS_RD_I;
          end
        end
        INIT: begin
          n <= n + 8'd1;
          if (&n) begin
            j     <= '0;
            k     <= '0;
            state <= KS_RD_I;
          end
        end
        KS_RD_I: state <= KS_RD_J;
        KS_RD_J: begin
          si <= perm_rd0;
          j  <= j_next;
          if ({{(rc4sc_pkg::LEN_W-KIDX_W){1'b0}}, k} == key_last) begin
            k <= '0;
          end else begin
            k <= k + 1'b1;
          end
          state <= KS_WR_I;
        end
        KS_WR_I: state <= KS_WR_J;
        KS_WR_J: begin
          n <= n + 8'd1;
          if (&n) begin
            i     <= '0;
            j     <= '0;
            state <= IDLE;
          end else begin
            state <= KS_RD_I;
          end
        end
        DS_RD_I: state <= DS_RD_J;
        DS_RD_J: begin
          si    <= perm_rd0;
          j     <= j_next;
          state <= DS_WR_I;
        end
        DS_WR_I: begin
          sj    <= perm_rd1;
          t     <= si + perm_rd1;
          state <= DS_WR_J;
        end
        DS_WR_J: begin
          out_byte  <= data ^ ks;
          out_valid <= 1'b1;
          state     <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  `RC4SC_ASSERT_NOW(a_strobe_idle, clk, rst, out_valid, state == IDLE)
  `RC4SC_ASSERT_NEXT(a_data_gives_word, clk, rst, state == DS_WR_J, out_valid)
  `RC4SC_ASSERT_NEXT(a_data_step_i, clk, rst, accept && func == rc4sc_pkg::FUNC_DATA,
                     state == DS_RD_I && i == 8'($past(i) + 8'd1))
  `RC4SC_ASSERT_NEXT(a_sched_clears_idx, clk, rst, state == KS_WR_J && n == 8'hFF,
                     i == 8'd0 && j == 8'd0 && state == IDLE)
  `RC4SC_ASSERT_NOW(a_key_idx_range, clk, rst, state == KS_RD_I || state == KS_RD_J,
                    {{(rc4sc_pkg::LEN_W-KIDX_W){1'b0}}, k} <= key_last)

endmodule

/* rtl/core/rc4_stream_cipher.sv */
// RC4 stream cipher top level: config register, key store, permutation store.
// Depends on rc4sc_pkg, rc4sc_perm_ram, rc4sc_key_ram and rc4sc_ctrl.
//
// Usage notes
// - Command channel: a word is taken on a rising edge with start high and
//   busy low. func picks the job: key byte write, key schedule, data byte.
// - Key byte write: stored at the taking edge; busy never rises.
//   Indices at or beyond MAX_KEY_BYTES are dropped.
// - Key schedule: identity fill of S, then the 256 swaps, each done as read
//   S[i] and key, read S[j], write S[i], write S[j]. i and j end cleared.
// - Data byte: read S[i], read S[j], write S[i] with the third read, write
//   S[j]; out_byte is registered in that last step and is on the ports with
//   out_valid high for one cycle. A new word can be taken in that same
//   strobe cycle, not before. The chain of three dependent reads, S[i],
//   S[j], then S[S[i]+S[j]], each waiting on the last, sets the pace.
// - Results cannot be held off; the strobe lasts exactly one cycle.
// - cfg_wr_en/cfg_wr_data write key_length; 0 or above MAX_KEY_BYTES means
//   MAX_KEY_BYTES. Write only while idle.
// - Reset (rst, synchronous): i, j cleared, key_length back to 16. Memories
//   are not cleared; a schedule must run before data words.
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = rc4sc_pkg::DEFAULT_MAX_KEY_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func,
  input  logic [7:0]                  key_index,
  input  logic [7:0]                  key_byte,
  input  logic [7:0]                  data_byte,
  input  logic                        cfg_wr_en,
  input  logic [rc4sc_pkg::LEN_W-1:0] cfg_wr_data,
  output logic [7:0]                  out_byte,
  output logic                        out_valid
);

  localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [rc4sc_pkg::LEN_W-1:0] MAX_LEN = rc4sc_pkg::LEN_W'(MAX_KEY_BYTES);

  logic [rc4sc_pkg::LEN_W-1:0] key_length;
  logic [rc4sc_pkg::LEN_W-1:0] eff_len;
  logic [rc4sc_pkg::LEN_W-1:0] key_last;
  logic                        key_we;
  logic [KIDX_W-1:0]           key_raddr;
  logic [7:0]                  key_rd;
  rc4sc_pkg::perm_req_t        perm_req;
  logic [7:0]                  perm_rd0;
  logic [7:0]                  perm_rd1;

  // key_length register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= rc4sc_pkg::KEY_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      key_length <= cfg_wr_data;
    end
  end

  // out-of-range lengths fold to the full key store
  assign eff_len  = (key_length == '0 || key_length > MAX_LEN) ? MAX_LEN : key_length;
  assign key_last = eff_len - 1'b1;

  // key byte writes complete at the taking edge
  assign key_we = start && !busy && (func == rc4sc_pkg::FUNC_KEY_WRITE) &&
                  ({1'b0, key_index} < MAX_LEN);

  rc4sc_key_ram #(
    .DEPTH (MAX_KEY_BYTES),
    .AW    (KIDX_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_index[KIDX_W-1:0]),
    .wdata (key_byte),
    .raddr (key_raddr),
    .rdata (key_rd)
  );

  rc4sc_perm_ram u_perm_ram (
    .clk (clk),
    .req (perm_req),
    .rd0 (perm_rd0),
    .rd1 (perm_rd1)
  );

  rc4sc_ctrl #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .KIDX_W        (KIDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .data_byte (data_byte),
    .key_last  (key_last),
    .perm_rd0  (perm_rd0),
    .perm_rd1  (perm_rd1),
    .key_rd    (key_rd),
    .perm_req  (perm_req),
    .key_raddr (key_raddr),
    .busy      (busy),
    .out_byte  (out_byte),
    .out_valid (out_valid)
  );

endmodule
